// ===== sv/aes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and functions of the AES block cipher
// S-box tables, round constants, GF(2^8) helpers and payload structs.
// ----------------------------------------------------------------------------
package aes_pkg;

	typedef struct packed {
		logic        kind;
		logic [63:0] block_first_half;
		logic [63:0] block_second_half;
	} aes_req_t;

	typedef struct packed {
		logic [63:0] result_first_half;
		logic [63:0] result_second_half;
	} aes_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} aes_state_t;

	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_KEYLEN = 3'd4;

	localparam logic [1:0] KL_128  = 2'd0;
	localparam logic [1:0] KL_192  = 2'd1;
	localparam logic [1:0] KL_256  = 2'd2;
	// Unused length code; behaves as a 256 bit key.
	localparam logic [1:0] KL_RSVD = 2'd3;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] RCON [11] = '{
		8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] subst_word(input logic [31:0] w);
		subst_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// One column of MixColumns, forward or inverse.
	function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] r  [4];
		for (int k = 0; k < 4; k++) begin
			a[k]  = c[31-8*k -: 8];
			x2[k] = xt(a[k]);
			x4[k] = xt(x2[k]);
			x8[k] = xt(x4[k]);
			if (inv) begin
				m2[k] = x8[k] ^ x4[k] ^ x2[k];
				m3[k] = x8[k] ^ x2[k] ^ a[k];
			end else begin
				m2[k] = x2[k];
				m3[k] = x2[k] ^ a[k];
			end
		end
		for (int rr = 0; rr < 4; rr++) begin
			if (inv)
				r[rr] = m2[rr] ^ m3[(rr+1)%4] ^ (x8[(rr+2)%4] ^ x4[(rr+2)%4] ^ a[(rr+2)%4])
					^ (x8[(rr+3)%4] ^ a[(rr+3)%4]);
			else
				r[rr] = m2[rr] ^ m3[(rr+1)%4] ^ a[(rr+2)%4] ^ a[(rr+3)%4];
		end
		mix_col = {r[0], r[1], r[2], r[3]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/aes_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_ram: generic single-port synchronous RAM
// One write and one read of the same address per cycle; read data registered.
// ----------------------------------------------------------------------------
module aes_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 15
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== sv/aes_block_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_cipher: iterative AES-128/192/256 encrypt and decrypt engine
// Round keys live in a 15 x 128 bit RAM; one round per cycle.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  request  | in_valid/in_ready  | in_data   (aes_req_t)
//  result   | out_valid/out_ready| out_data  (aes_rsp_t)
//  config   | cfg_we             | cfg_index, cfg_wdata
//
//  After acceptance a request passes ST_LOAD, then ST_ROUND with one round per
//  cycle paced by the round key RAM read, then ST_DONE, which moves the
//  block into the output register.
//  The engine takes a new request only in ST_IDLE, after the last left ST_DONE.
//  After reset or a key or key length write the first request first runs
//  key expansion, one 32 bit schedule word per cycle, then a prefetch step.
//  A new request is taken while the previous result waits for out_ready;
//  the finished block then stalls until the output register frees up.
// ----------------------------------------------------------------------------
module aes_block_cipher
	import aes_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire aes_req_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output aes_rsp_t         out_data,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata
);
	localparam int RK_ROWS = 15;

	aes_state_t state_q, state_d;

	logic [63:0]  key_q [4];
	logic [1:0]   klen_q;
	logic         keys_ready_q;

	// Expansion: sliding window of the last nk schedule words (8 entries).
	logic [31:0]  win_q [8];
	logic [5:0]   widx_q;
	logic [3:0]   nk_q;
	logic [3:0]   kmod_q;
	logic [3:0]   rci_q;
	logic [127:0] row_q;
	logic [3:0]   nr_q;
	logic [2:0]   last_idx;

	logic         dec_q;
	logic [127:0] st_q;
	logic [3:0]   rnd_q;
	logic         ovalid_q;
	aes_rsp_t     obuf_q;

	logic         ram_we;
	logic [3:0]   ram_addr;
	logic [3:0]   pre_addr;
	logic [3:0]   addr_mux;
	logic [127:0] ram_wdata, ram_rdata;

	aes_ram #(.WIDTH(128), .DEPTH(RK_ROWS)) u_rk_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (addr_mux),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign last_idx = 3'(nk_q - 4'd1);

	// Next schedule word from the window.
	logic [31:0] prev_w, t_w, new_w, next_w;
	logic [3:0]  nk_n, total_rows;
	logic [5:0]  total_w;
	always_comb begin
		prev_w = win_q[last_idx];
		t_w    = prev_w;
		if (kmod_q == 4'd0)
			t_w = subst_word({prev_w[23:0], prev_w[31:24]}) ^ {RCON[rci_q], 24'd0};
		else if (nk_q == 4'd8 && kmod_q == 4'd4)
			t_w = subst_word(prev_w);
		new_w = win_q[0] ^ t_w;
		// The first nk words are the key itself.
		next_w = (widx_q < {2'b00, nk_q}) ? win_q[widx_q[2:0]] : new_w;
		unique case (klen_q)
			KL_128:  begin nk_n = 4'd4; total_rows = 4'd11; end
			KL_192:  begin nk_n = 4'd6; total_rows = 4'd13; end
			default: begin nk_n = 4'd8; total_rows = 4'd15; end
		endcase
		total_w = {total_rows, 2'b00};
	end

	// Round datapath.
	logic [127:0] sb, mx, rnd_out;
	logic [7:0]   bi [16];
	logic [7:0]   bo [16];
	logic         last_rnd;
	always_comb begin
		for (int k = 0; k < 16; k++)
			bi[k] = st_q[127-8*k -: 8];
		for (int rr = 0; rr < 4; rr++)
			for (int c = 0; c < 4; c++)
				bo[4*c+rr] = dec_q ? INV_SBOX[bi[4*((c+4-rr)%4)+rr]]
					: SBOX[bi[4*((c+rr)%4)+rr]];
		for (int k = 0; k < 16; k++)
			sb[127-8*k -: 8] = bo[k];
		last_rnd = (rnd_q == nr_q);
		for (int c = 0; c < 4; c++) begin
			if (dec_q)
				mx[127-32*c -: 32] = mix_col(sb[127-32*c -: 32] ^ ram_rdata[127-32*c -: 32],
					1'b1);
			else
				mx[127-32*c -: 32] = mix_col(sb[127-32*c -: 32], 1'b0);
		end
		if (last_rnd)
			rnd_out = sb ^ ram_rdata;
		else if (dec_q)
			rnd_out = mx;
		else
			rnd_out = mx ^ ram_rdata;
	end

	// Control: hold in_ready low while the engine is busy.
	logic accept;
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = {row_q[95:0], next_w};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_ready)
					state_d = keys_ready_q ? ST_LOAD : ST_EXPAND;
				ram_addr = in_data.kind ? nr_q : 4'd0;
				if (!keys_ready_q)
					ram_addr = 4'd0;
			end
			ST_EXPAND: begin
				ram_we   = (widx_q[1:0] == 2'b11);
				ram_addr = widx_q[5:2];
				// Spare cycle after the last word: no write, prefetch instead.
				if (widx_q == total_w) begin
					ram_we  = 1'b0;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ram_addr = dec_q ? (nr_q - 4'd1) : 4'd1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				ram_addr = dec_q ? (nr_q - rnd_q - 4'd1) : (rnd_q + 4'd1);
				if (last_rnd)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!ovalid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		accept = (state_q == ST_IDLE) && in_valid && in_ready;
	end

	// ST_LOAD needs row 0 or row Nr in rdata: issue that read in the spare cycle.
	assign pre_addr = dec_q ? nr_q : 4'd0;

	always_comb begin
		addr_mux = ram_addr;
		if (state_q == ST_EXPAND && widx_q == total_w)
			addr_mux = pre_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				key_q[k] <= '0;
			klen_q       <= KL_128;
			keys_ready_q <= 1'b0;
			nr_q         <= 4'd10;
			ovalid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				priority case (cfg_index)
					REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
						key_q[cfg_index[1:0]] <= cfg_wdata;
						keys_ready_q <= 1'b0;
					end
					REG_KEYLEN: begin
						klen_q       <= cfg_wdata[1:0];
						keys_ready_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (accept && !keys_ready_q) begin
				nr_q         <= total_rows - 4'd1;
				keys_ready_q <= 1'b1;
			end
			if (out_valid && out_ready)
				ovalid_q <= 1'b0;
			if (state_q == ST_DONE && (!ovalid_q || out_ready))
				ovalid_q <= 1'b1;
		end
	end

	// Request capture, expansion window and row assembly (drop the oldest word, advance), rounds and output buffer.
	always_ff @(posedge clk) begin
		if (accept) begin
			dec_q  <= in_data.kind;
			st_q   <= {in_data.block_first_half, in_data.block_second_half};
			nk_q   <= nk_n;
			kmod_q <= 4'd0;
			rci_q  <= 4'd1;
			widx_q <= 6'd0;
			for (int k = 0; k < 8; k++)
				win_q[k] <= (k < 2*4) ? ((k%2 == 0) ? key_q[k/2][63:32] : key_q[k/2][31:0])
					: 32'd0;
		end else if (state_q == ST_EXPAND && widx_q != total_w) begin
			// First nk words are the key itself; later words slide the window.
			if (widx_q < {2'b00, nk_q}) begin
				row_q <= {row_q[95:0], win_q[widx_q[2:0]]};
			end else begin
				row_q <= {row_q[95:0], new_w};
				for (int k = 0; k < 7; k++)
					win_q[k] <= win_q[k+1];
				win_q[last_idx] <= new_w;
				if (kmod_q == nk_q - 4'd1) begin
					kmod_q <= 4'd0;
					rci_q  <= rci_q + 4'd1;
				end else begin
					kmod_q <= kmod_q + 4'd1;
				end
			end
			widx_q <= widx_q + 6'd1;
		end
		if (state_q == ST_LOAD) begin
			st_q  <= st_q ^ ram_rdata;
			rnd_q <= 4'd1;
		end else if (state_q == ST_ROUND) begin
			st_q  <= rnd_out;
			rnd_q <= rnd_q + 4'd1;
		end
		if (state_q == ST_DONE && (!ovalid_q || out_ready))
			obuf_q <= '{result_first_half: st_q[127:64], result_second_half: st_q[63:0]};
	end

	assign out_valid = ovalid_q;
	assign out_data  = obuf_q;

endmodule
`default_nettype wire
